// ===== hw/rtl/sri_pkg.sv =====
// Package with the shared constant of the segment and rectangle intersection block.
package sri_pkg;

  localparam int COORD_BITS_DEF = 16;

endpackage

// ===== hw/rtl/sri_prep.sv =====
// First stage: coordinate differences, rectangle corners and endpoint containment.
module sri_prep #(
  parameter int COORD_BITS = sri_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_BITS-1:0]  in_start_x,
  input  logic signed [COORD_BITS-1:0]  in_start_y,
  input  logic signed [COORD_BITS-1:0]  in_end_x,
  input  logic signed [COORD_BITS-1:0]  in_end_y,
  input  logic signed [COORD_BITS-1:0]  in_rect_left,
  input  logic signed [COORD_BITS-1:0]  in_rect_top,
  input  logic        [COORD_BITS-2:0]  in_rect_width,
  input  logic        [COORD_BITS-2:0]  in_rect_height,
  input  logic                          nxt_ready,
  output logic                          s1_valid,
  output logic signed [COORD_BITS+1:0]  s1_dx,
  output logic signed [COORD_BITS+1:0]  s1_dy,
  output logic signed [COORD_BITS+1:0]  s1_oxl,
  output logic signed [COORD_BITS+1:0]  s1_oxr,
  output logic signed [COORD_BITS+1:0]  s1_oyt,
  output logic signed [COORD_BITS+1:0]  s1_oyb,
  output logic signed [COORD_BITS+1:0]  s1_w,
  output logic signed [COORD_BITS+1:0]  s1_h,
  output logic                          s1_inside
);
  import sri_pkg::*;

  localparam int W = COORD_BITS + 2;

  logic signed [W-1:0] sx_e, sy_e, ex_e, ey_e, l_e, t_e, w_e, h_e, r_e, b_e;
  logic                start_in, end_in;

  logic                valid_r;
  logic signed [W-1:0] dx_r, dy_r, oxl_r, oxr_r, oyt_r, oyb_r, w_r, h_r;
  logic                inside_r;

  always_comb begin
    sx_e = W'(in_start_x);
    sy_e = W'(in_start_y);
    ex_e = W'(in_end_x);
    ey_e = W'(in_end_y);
    l_e  = W'(in_rect_left);
    t_e  = W'(in_rect_top);
    w_e  = signed'({3'b000, in_rect_width});
    h_e  = signed'({3'b000, in_rect_height});
    r_e  = l_e + w_e;
    b_e  = t_e + h_e;
    // Half-open bounds: the right and bottom edges are outside.
    start_in = (sx_e >= l_e) && (sx_e < r_e) && (sy_e >= t_e) && (sy_e < b_e);
    end_in   = (ex_e >= l_e) && (ex_e < r_e) && (ey_e >= t_e) && (ey_e < b_e);
  end

  assign in_ready = !valid_r || nxt_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      dx_r     <= ex_e - sx_e;
      dy_r     <= ey_e - sy_e;
      oxl_r    <= sx_e - l_e;
      oxr_r    <= sx_e - r_e;
      oyt_r    <= sy_e - t_e;
      oyb_r    <= sy_e - b_e;
      w_r      <= w_e;
      h_r      <= h_e;
      inside_r <= start_in || end_in;
    end
  end

  assign s1_valid  = valid_r;
  assign s1_dx     = dx_r;
  assign s1_dy     = dy_r;
  assign s1_oxl    = oxl_r;
  assign s1_oxr    = oxr_r;
  assign s1_oyt    = oyt_r;
  assign s1_oyb    = oyb_r;
  assign s1_w      = w_r;
  assign s1_h      = h_r;
  assign s1_inside = inside_r;

endmodule

// ===== hw/rtl/sri_mult.sv =====
// Second stage: the cross-product terms of the four rectangle sides.
module sri_mult #(
  parameter int COORD_BITS = sri_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            s1_valid,
  output logic                            s1_ready,
  input  logic signed [COORD_BITS+1:0]    s1_dx,
  input  logic signed [COORD_BITS+1:0]    s1_dy,
  input  logic signed [COORD_BITS+1:0]    s1_oxl,
  input  logic signed [COORD_BITS+1:0]    s1_oxr,
  input  logic signed [COORD_BITS+1:0]    s1_oyt,
  input  logic signed [COORD_BITS+1:0]    s1_oyb,
  input  logic signed [COORD_BITS+1:0]    s1_w,
  input  logic signed [COORD_BITS+1:0]    s1_h,
  input  logic                            s1_inside,
  input  logic                            nxt_ready,
  output logic                            s2_valid,
  output logic signed [2*COORD_BITS+3:0]  s2_dyw,
  output logic signed [2*COORD_BITS+3:0]  s2_dxh,
  output logic signed [2*COORD_BITS+3:0]  s2_oytw,
  output logic signed [2*COORD_BITS+3:0]  s2_oybw,
  output logic signed [2*COORD_BITS+3:0]  s2_oxlh,
  output logic signed [2*COORD_BITS+3:0]  s2_oxrh,
  output logic signed [2*COORD_BITS+3:0]  s2_oytdx,
  output logic signed [2*COORD_BITS+3:0]  s2_oybdx,
  output logic signed [2*COORD_BITS+3:0]  s2_oxldy,
  output logic signed [2*COORD_BITS+3:0]  s2_oxrdy,
  output logic                            s2_inside
);
  import sri_pkg::*;

  localparam int P = 2 * COORD_BITS + 4;

  logic                valid_r;
  logic signed [P-1:0] dyw_r, dxh_r, oytw_r, oybw_r, oxlh_r, oxrh_r;
  logic signed [P-1:0] oytdx_r, oybdx_r, oxldy_r, oxrdy_r;
  logic                inside_r;

  assign s1_ready = !valid_r || nxt_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s1_ready) begin
      valid_r <= s1_valid;
    end
  end

  // Every side is axis-aligned, so one term of each side vector is zero and
  // each cross product needs only the products below.
  always_ff @(posedge clk) begin
    if (s1_valid && s1_ready) begin
      dyw_r    <= P'(s1_dy) * P'(s1_w);
      dxh_r    <= P'(s1_dx) * P'(s1_h);
      oytw_r   <= P'(s1_oyt) * P'(s1_w);
      oybw_r   <= P'(s1_oyb) * P'(s1_w);
      oxlh_r   <= P'(s1_oxl) * P'(s1_h);
      oxrh_r   <= P'(s1_oxr) * P'(s1_h);
      oytdx_r  <= P'(s1_oyt) * P'(s1_dx);
      oybdx_r  <= P'(s1_oyb) * P'(s1_dx);
      oxldy_r  <= P'(s1_oxl) * P'(s1_dy);
      oxrdy_r  <= P'(s1_oxr) * P'(s1_dy);
      inside_r <= s1_inside;
    end
  end

  assign s2_valid  = valid_r;
  assign s2_dyw    = dyw_r;
  assign s2_dxh    = dxh_r;
  assign s2_oytw   = oytw_r;
  assign s2_oybw   = oybw_r;
  assign s2_oxlh   = oxlh_r;
  assign s2_oxrh   = oxrh_r;
  assign s2_oytdx  = oytdx_r;
  assign s2_oybdx  = oybdx_r;
  assign s2_oxldy  = oxldy_r;
  assign s2_oxrdy  = oxrdy_r;
  assign s2_inside = inside_r;

endmodule

// ===== hw/rtl/sri_decide.sv =====
// Third stage: parameter range tests per side and the registered hit word.
module sri_decide #(
  parameter int COORD_BITS = sri_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            s2_valid,
  output logic                            s2_ready,
  input  logic signed [2*COORD_BITS+3:0]  s2_dyw,
  input  logic signed [2*COORD_BITS+3:0]  s2_dxh,
  input  logic signed [2*COORD_BITS+3:0]  s2_oytw,
  input  logic signed [2*COORD_BITS+3:0]  s2_oybw,
  input  logic signed [2*COORD_BITS+3:0]  s2_oxlh,
  input  logic signed [2*COORD_BITS+3:0]  s2_oxrh,
  input  logic signed [2*COORD_BITS+3:0]  s2_oytdx,
  input  logic signed [2*COORD_BITS+3:0]  s2_oybdx,
  input  logic signed [2*COORD_BITS+3:0]  s2_oxldy,
  input  logic signed [2*COORD_BITS+3:0]  s2_oxrdy,
  input  logic                            s2_inside,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_hit
);
  import sri_pkg::*;

  localparam int Q = 2 * COORD_BITS + 5;

  // True when n / d lies in [0, 1]; d is known to be nonzero.
  function automatic logic in_unit(input logic signed [Q-1:0] n,
                                   input logic signed [Q-1:0] d);
    logic res;
    if (d < 0) begin
      res = (d <= n) && (n <= 0);
    end else begin
      res = (n >= 0) && (n <= d);
    end
    return res;
  endfunction

  logic signed [Q-1:0] den_top, den_rgt, den_bot, den_lft;
  logic signed [Q-1:0] n1_top, n1_rgt, n1_bot, n1_lft;
  logic signed [Q-1:0] n2_top, n2_rgt, n2_bot, n2_lft;
  logic                hit_top, hit_rgt, hit_bot, hit_lft, hit_nxt;

  logic                valid_r;
  logic                hit_r;

  always_comb begin
    den_top = -Q'(s2_dyw);
    n1_top  = Q'(s2_oytw);
    n2_top  = Q'(s2_oytdx) - Q'(s2_oxldy);

    den_rgt = Q'(s2_dxh);
    n1_rgt  = -Q'(s2_oxrh);
    n2_rgt  = Q'(s2_oytdx) - Q'(s2_oxrdy);

    den_bot = Q'(s2_dyw);
    n1_bot  = -Q'(s2_oybw);
    n2_bot  = Q'(s2_oybdx) - Q'(s2_oxrdy);

    den_lft = -Q'(s2_dxh);
    n1_lft  = Q'(s2_oxlh);
    n2_lft  = Q'(s2_oybdx) - Q'(s2_oxldy);

    // A side parallel to the segment has a zero denominator and is skipped.
    hit_top = (den_top != 0) && in_unit(n1_top, den_top) && in_unit(n2_top, den_top);
    hit_rgt = (den_rgt != 0) && in_unit(n1_rgt, den_rgt) && in_unit(n2_rgt, den_rgt);
    hit_bot = (den_bot != 0) && in_unit(n1_bot, den_bot) && in_unit(n2_bot, den_bot);
    hit_lft = (den_lft != 0) && in_unit(n1_lft, den_lft) && in_unit(n2_lft, den_lft);
    hit_nxt = s2_inside || hit_top || hit_rgt || hit_bot || hit_lft;
  end

  assign s2_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s2_ready) begin
      valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s2_ready) begin
      hit_r <= hit_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_hit   = hit_r;

endmodule

// ===== hw/rtl/segment_rect_intersect.sv =====
// Top level of the segment versus axis-aligned rectangle intersection test.
//
//   channel  direction  handshake              words
//   in_      input      in_valid / in_ready    segment endpoints and rectangle
//   out_     output     out_valid / out_ready  hit flag
//
// One word is accepted per cycle while the output is not stalled, and it passes
// through the difference, product and range-test registers in turn to its hit word.
// Synchronous active-low reset clears the stage valid flags only.
// A stalled output holds its word; each stage still loads while the stage
// after it is empty or draining, so bubbles are squeezed out.
module segment_rect_intersect #(
  parameter int COORD_BITS = sri_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_BITS-1:0]  in_start_x,
  input  logic signed [COORD_BITS-1:0]  in_start_y,
  input  logic signed [COORD_BITS-1:0]  in_end_x,
  input  logic signed [COORD_BITS-1:0]  in_end_y,
  input  logic signed [COORD_BITS-1:0]  in_rect_left,
  input  logic signed [COORD_BITS-1:0]  in_rect_top,
  input  logic        [COORD_BITS-2:0]  in_rect_width,
  input  logic        [COORD_BITS-2:0]  in_rect_height,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit
);
  import sri_pkg::*;

  localparam int W = COORD_BITS + 2;
  localparam int P = 2 * W;

  logic                s1_valid, s1_ready, s1_inside;
  logic signed [W-1:0] s1_dx, s1_dy, s1_oxl, s1_oxr, s1_oyt, s1_oyb, s1_w, s1_h;

  logic                s2_valid, s2_ready, s2_inside;
  logic signed [P-1:0] s2_dyw, s2_dxh, s2_oytw, s2_oybw, s2_oxlh, s2_oxrh;
  logic signed [P-1:0] s2_oytdx, s2_oybdx, s2_oxldy, s2_oxrdy;

  sri_prep #(.COORD_BITS(COORD_BITS)) u_prep (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .in_rect_left   (in_rect_left),
    .in_rect_top    (in_rect_top),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .nxt_ready      (s1_ready),
    .s1_valid       (s1_valid),
    .s1_dx          (s1_dx),
    .s1_dy          (s1_dy),
    .s1_oxl         (s1_oxl),
    .s1_oxr         (s1_oxr),
    .s1_oyt         (s1_oyt),
    .s1_oyb         (s1_oyb),
    .s1_w           (s1_w),
    .s1_h           (s1_h),
    .s1_inside      (s1_inside)
  );

  sri_mult #(.COORD_BITS(COORD_BITS)) u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_ready  (s1_ready),
    .s1_dx     (s1_dx),
    .s1_dy     (s1_dy),
    .s1_oxl    (s1_oxl),
    .s1_oxr    (s1_oxr),
    .s1_oyt    (s1_oyt),
    .s1_oyb    (s1_oyb),
    .s1_w      (s1_w),
    .s1_h      (s1_h),
    .s1_inside (s1_inside),
    .nxt_ready (s2_ready),
    .s2_valid  (s2_valid),
    .s2_dyw    (s2_dyw),
    .s2_dxh    (s2_dxh),
    .s2_oytw   (s2_oytw),
    .s2_oybw   (s2_oybw),
    .s2_oxlh   (s2_oxlh),
    .s2_oxrh   (s2_oxrh),
    .s2_oytdx  (s2_oytdx),
    .s2_oybdx  (s2_oybdx),
    .s2_oxldy  (s2_oxldy),
    .s2_oxrdy  (s2_oxrdy),
    .s2_inside (s2_inside)
  );

  sri_decide #(.COORD_BITS(COORD_BITS)) u_decide (
    .clk       (clk),
    .rst_n     (rst_n),
    .s2_valid  (s2_valid),
    .s2_ready  (s2_ready),
    .s2_dyw    (s2_dyw),
    .s2_dxh    (s2_dxh),
    .s2_oytw   (s2_oytw),
    .s2_oybw   (s2_oybw),
    .s2_oxlh   (s2_oxlh),
    .s2_oxrh   (s2_oxrh),
    .s2_oytdx  (s2_oytdx),
    .s2_oybdx  (s2_oybdx),
    .s2_oxldy  (s2_oxldy),
    .s2_oxrdy  (s2_oxrdy),
    .s2_inside (s2_inside),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_hit   (out_hit)
  );

endmodule
